FILE: rtl/core/spq_pkg.sv
// Stable priority queue package: sizes, operation and status codes,
// payload structs for both channels and the per-cell slot and command types.
// No dependencies.
package spq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int PRIO_W     = 8;
	localparam int OCC_W      = 5;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic                  func;
		logic [PRIO_W-1:0]     job_priority;
		logic [DATA_WIDTH-1:0] job_data;
	} cmd_item_t;

	typedef struct packed {
		logic [PRIO_W-1:0]     out_priority;
		logic [DATA_WIDTH-1:0] out_data;
		logic [1:0]            status;
		logic                  queue_empty;
		logic [OCC_W-1:0]      occupancy;
	} rsp_item_t;

	typedef struct packed {
		logic [PRIO_W-1:0]     prio;
		logic [DATA_WIDTH-1:0] data;
	} slot_t;

	typedef struct packed {
		logic  enq;
		logic  deq;
		slot_t new_slot;
	} cell_cmd_t;

endpackage

FILE: rtl/core/spq_cell.sv
// One slot of the sorted chain: holds a job and moves it toward either
// neighbor on enqueue or dequeue. Depends on spq_pkg.
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_cmd_t cmd,
	input  logic               occupied,
	input  logic               left_keep,
	input  spq_pkg::slot_t     left_slot,
	input  spq_pkg::slot_t     right_slot,
	output logic               keep,
	output spq_pkg::slot_t     slot
);
	import spq_pkg::*;

	slot_t slot_q;

	// held job stays in place when it ranks ahead of or equal to the new one
	assign keep = occupied && (slot_q.prio >= cmd.new_slot.prio);
	assign slot = slot_q;

	always_ff @(posedge clk) begin
		if (cmd.deq) begin
			slot_q <= right_slot;
		end else if (cmd.enq && !keep) begin
			if (left_keep) begin
				slot_q <= cmd.new_slot;
			end else begin
				slot_q <= left_slot;
			end
		end
	end

endmodule

FILE: rtl/core/stable_priority_queue_top.sv
// Stable priority queue top level: row of spq_cell slots, occupancy counter
// and registered response stage. Depends on spq_pkg and spq_cell.
//
// Usage:
//   cmd channel (cmd_valid, cmd_stall, cmd) carries one operation per
//   transfer: enqueue a job (priority, data word) or dequeue the front job.
//   rsp channel (rsp_valid, rsp_stall, rsp) returns exactly one response per
//   command: dequeued job or zeros, status, empty flag and occupancy.
//   Higher priority leaves first; equal priorities leave in arrival order.
//   Dequeue on empty and enqueue on full report a status and change nothing.
// Latency: the response is valid the cycle after the command transfer.
// Throughput: one command per cycle while cmd_stall is low. Every cell updates
//   from its neighbors in parallel, so insert and remove both finish together.
// Reset: the queue is empty and no response is pending; slot contents are
//   not cleared since only occupied slots are ever read.
// Stall: while a response waits under rsp_stall, cmd_stall is raised; the
//   response is held unchanged until it transfers.
module stable_priority_queue_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  spq_pkg::cmd_item_t cmd,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output spq_pkg::rsp_item_t rsp
);
	import spq_pkg::*;

	logic             accept;
	logic             do_enq;
	logic             do_deq;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	cell_cmd_t        cell_cmd;
	slot_t            slot [DEPTH];
	logic             keep [DEPTH];
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;
	rsp_item_t        rsp_d;

	assign cmd_stall = rsp_valid_q && rsp_stall;
	assign accept    = cmd_valid && !cmd_stall;
	assign do_enq    = accept && (cmd.func == FUNC_ENQ) && (count_q != CNT_W'(DEPTH));
	assign do_deq    = accept && (cmd.func == FUNC_DEQ) && (count_q != '0);

	always_comb begin
		cell_cmd.enq               = do_enq;
		cell_cmd.deq               = do_deq;
		cell_cmd.new_slot.prio     = cmd.job_priority;
		cell_cmd.new_slot.data     = cmd.job_data;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic  occ;
		logic  lk;
		slot_t ls;
		slot_t rs;

		assign occ = CNT_W'(i) < count_q;

		if (i == 0) begin : g_head
			assign lk = 1'b1;
			assign ls = cmd.func ? slot[i] : cell_cmd.new_slot;
		end else begin : g_body
			assign lk = keep[i-1];
			assign ls = slot[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign rs = slot[i];
		end else begin : g_mid
			assign rs = slot[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.cmd        (cell_cmd),
			.occupied   (occ),
			.left_keep  (lk),
			.left_slot  (ls),
			.right_slot (rs),
			.keep       (keep[i]),
			.slot       (slot[i])
		);
	end

	always_comb begin
		count_d = count_q;
		if (do_enq) begin
			count_d = count_q + CNT_W'(1);
		end else if (do_deq) begin
			count_d = count_q - CNT_W'(1);
		end

		rsp_d.out_priority = '0;
		rsp_d.out_data     = '0;
		rsp_d.status       = STAT_OK;
		if (do_deq) begin
			rsp_d.out_priority = slot[0].prio;
			rsp_d.out_data     = slot[0].data;
		end
		if (cmd.func == FUNC_DEQ && count_q == '0) begin
			rsp_d.status = STAT_EMPTY;
		end else if (cmd.func == FUNC_ENQ && count_q == CNT_W'(DEPTH)) begin
			rsp_d.status = STAT_FULL;
		end
		rsp_d.queue_empty = (count_d == '0);
		rsp_d.occupancy   = OCC_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: rtl/core/spq_checker.sv
// Port-level checks for stable_priority_queue_top and the bind that
// attaches them. Depends on spq_pkg and stable_priority_queue_top.
module spq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_stall,
	input spq_pkg::cmd_item_t cmd,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input spq_pkg::rsp_item_t rsp
);
	import spq_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_cmd_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> rsp_valid)
		else $error("command transfer without response");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.queue_empty == (rsp.occupancy == '0))
			&& (rsp.occupancy <= OCC_W'(DEPTH)))
		else $error("empty flag or occupancy inconsistent");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != STAT_OK) |-> (rsp.out_priority == '0)
			&& (rsp.out_data == '0))
		else $error("failed step returned job data");

	a_cmd_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> rsp_valid && rsp_stall)
		else $error("command stalled with no pending response");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
